@@ src/obrb_pkg.sv @@
// Shared constants, codes and control structs of the overwriting byte ring buffer.
// No dependencies; every other file of the block but obrb_ram imports this package.
package obrb_pkg;

   localparam int DEPTH     = 256;
   localparam int MAX_BURST = 64;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int LEN_W     = 7;
   localparam int BYTE_W    = 8;
   localparam int ACT_W     = 2;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

   typedef enum logic [ACT_W-1:0] {
      ACT_PUT  = 2'd0,
      ACT_GET  = 2'd1,
      ACT_HEAD = 2'd2,
      ACT_POKE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_STREAM = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // input item taken this cycle
      logic issue;    // read and present the next byte of a get
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;   // output register is free at this edge
      logic get_multi;   // offered item is a get that returns two or more bytes
      logic rem_last;    // one byte of the current get is left to read
   } status_type;

endpackage

@@ src/obrb_if.sv @@
// Valid/ready channel interfaces for request items and result items.
// Depends on obrb_pkg for field widths.
interface obrb_req_if import obrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [BYTE_W-1:0] data_byte;
   logic [LEN_W-1:0]  max_len;
   logic [PTR_W-1:0]  position;

   modport source (output valid, action, data_byte, max_len, position, input ready);
   modport sink   (input valid, action, data_byte, max_len, position, output ready);
endinterface

interface obrb_rsp_if import obrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_out;
   logic              byte_valid;
   logic              last;
   logic [LEN_W-1:0]  bytes_read;
   logic [CNT_W-1:0]  fill_count;
   logic              is_empty;
   logic              is_full;
   logic              overwrote;
   logic              bad_position;

   modport source (output valid, byte_out, byte_valid, last, bytes_read, fill_count,
                   is_empty, is_full, overwrote, bad_position, input ready);
   modport sink   (input valid, byte_out, byte_valid, last, bytes_read, fill_count,
                   is_empty, is_full, overwrote, bad_position, output ready);
endinterface

@@ src/obrb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module obrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/obrb_ctrl.sv @@
// Controller: accepts items and sequences the byte stream of a get.
// Depends on obrb_pkg for the state encoding and the command/status structs.
module obrb_ctrl import obrb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // take an item only when idle and the output register frees up
   assign req_ready  = (state_ff == ST_IDLE) && status.slot_free;
   assign cmd.accept = req_valid && req_ready;
   assign cmd.issue  = (state_ff == ST_STREAM) && status.slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.get_multi) begin
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            if (cmd.issue && status.rem_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_accept_in_stream: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> !req_ready)
      else $error("item offered ready while a get is streaming");

   a_accept_issue_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.issue))
      else $error("accept and byte issue in the same cycle");

   a_stream_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && status.rem_last) |=> (state_ff == ST_IDLE))
      else $error("stream did not end after its last byte");

endmodule

@@ src/obrb_datapath.sv @@
// Datapath: pointers, fill count, capacity register, byte store and result register.
// Depends on obrb_pkg and instantiates obrb_ram.
module obrb_datapath import obrb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [LEN_W-1:0]  req_max_len,
   input  logic [PTR_W-1:0]  req_position,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_byte_out,
   output logic              rsp_byte_valid,
   output logic              rsp_last,
   output logic [LEN_W-1:0]  rsp_bytes_read,
   output logic [CNT_W-1:0]  rsp_fill_count,
   output logic              rsp_is_empty,
   output logic              rsp_is_full,
   output logic              rsp_overwrote,
   output logic              rsp_bad_position,
   input  logic              csr_we,
   input  logic [CNT_W-1:0]  csr_wdata
);

   // architectural state
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] rem_ff, rem_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             byte_valid_ff, byte_valid_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] nread_ff, nread_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             empty_ff, empty_in;
   logic             full_ff, full_in;
   logic             ovw_ff, ovw_in;
   logic             bad_ff, bad_in;

   // store port
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic              ram_re;
   logic [BYTE_W-1:0] ram_q;

   // decode and arithmetic
   action_type       act;
   logic [LEN_W-1:0] want;
   logic [CNT_W-1:0] want_w;
   logic [CNT_W-1:0] n_w;
   logic [LEN_W-1:0] n;
   logic [CNT_W-1:0] wp_inc, rp_inc;
   logic [PTR_W-1:0] wp_wrap, rp_wrap;
   logic [CNT_W-1:0] pos_w, wp_w;
   logic             pos_bad;
   logic [CNT_W-1:0] added;
   logic [CNT_W:0]   grown;
   logic             grown_over;
   logic             is_at_cap;
   logic [CNT_W-1:0] cap_clamped;
   logic             slot_free;

   assign act    = action_type'(req_action);
   assign want   = (req_max_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : req_max_len;
   assign want_w = CNT_W'(want);
   assign n_w    = (want_w > cnt_ff) ? cnt_ff : want_w;
   assign n      = n_w[LEN_W-1:0];

   // advance a pointer by one with wrap at capacity
   assign wp_inc  = CNT_W'(wp_ff) + CNT_W'(1);
   assign rp_inc  = CNT_W'(rp_ff) + CNT_W'(1);
   assign wp_wrap = (wp_inc >= cap_ff) ? '0 : wp_inc[PTR_W-1:0];
   assign rp_wrap = (rp_inc >= cap_ff) ? '0 : rp_inc[PTR_W-1:0];

   // head update distance; on overflow the buffer ends full, so read meets write
   assign pos_w      = CNT_W'(req_position);
   assign wp_w       = CNT_W'(wp_ff);
   assign pos_bad    = (pos_w >= cap_ff);
   assign added      = (pos_w > wp_w) ? (pos_w - wp_w) : (cap_ff - wp_w + pos_w);
   assign grown      = {1'b0, cnt_ff} + {1'b0, added};
   assign grown_over = (grown > {1'b0, cap_ff});
   assign is_at_cap  = (cnt_ff >= cap_ff);

   // clamp a written capacity into one to DEPTH
   assign cap_clamped = (csr_wdata == '0) ? CNT_W'(1) :
                        (csr_wdata > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : csr_wdata;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign status.slot_free = slot_free;
   assign status.get_multi = (act == ACT_GET) && (n_w > CNT_W'(1));
   assign status.rem_last  = (rem_ff == LEN_W'(1));

   // next state of pointers, count and result register
   always_comb begin
      cap_in        = cap_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      byte_valid_in = byte_valid_ff;
      last_in       = last_ff;
      nread_in      = nread_ff;
      fill_in       = fill_ff;
      empty_in      = empty_ff;
      full_in       = full_ff;
      ovw_in        = ovw_ff;
      bad_in        = bad_ff;
      ram_we        = 1'b0;
      ram_waddr     = wp_ff;
      ram_re        = 1'b0;

      if (csr_we) begin
         // new capacity empties the buffer
         cap_in = cap_clamped;
         wp_in  = '0;
         rp_in  = '0;
         cnt_in = '0;
      end else if (cmd.accept) begin
         byte_valid_in = 1'b0;
         last_in       = 1'b1;
         nread_in      = '0;
         ovw_in        = 1'b0;
         bad_in        = 1'b0;
         case (act)
            ACT_PUT: begin
               ram_we = 1'b1;
               wp_in  = wp_wrap;
               if (is_at_cap) begin
                  // drop the oldest byte
                  rp_in  = rp_wrap;
                  cnt_in = cap_ff;
                  ovw_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ACT_GET: begin
               cnt_in = cnt_ff - n_w;
               if (n != '0) begin
                  // read the first byte now
                  ram_re        = 1'b1;
                  rp_in         = rp_wrap;
                  rem_in        = n - LEN_W'(1);
                  byte_valid_in = 1'b1;
                  last_in       = (n == LEN_W'(1));
                  nread_in      = n;
               end
            end
            ACT_HEAD: begin
               bad_in = pos_bad;
               if (!pos_bad && (req_position != wp_ff)) begin
                  wp_in = req_position;
                  if (grown_over) begin
                     rp_in  = req_position;
                     cnt_in = cap_ff;
                     ovw_in = 1'b1;
                  end else begin
                     cnt_in = grown[CNT_W-1:0];
                  end
               end
            end
            ACT_POKE: begin
               bad_in    = pos_bad;
               ram_we    = !pos_bad;
               ram_waddr = req_position;
            end
            default: begin
               bad_in = 1'b0;
            end
         endcase
         rsp_valid_in = 1'b1;
         fill_in      = cnt_in;
         empty_in     = (cnt_in == '0);
         full_in      = (cnt_in == cap_ff);
      end else if (cmd.issue) begin
         // stream the next byte; status fields hold
         ram_re       = 1'b1;
         rp_in        = rp_wrap;
         rem_in       = rem_ff - LEN_W'(1);
         rsp_valid_in = 1'b1;
         last_in      = (rem_ff == LEN_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      nread_ff      <= nread_in;
      fill_ff       <= fill_in;
      empty_ff      <= empty_in;
      full_ff       <= full_in;
      ovw_ff        <= ovw_in;
      bad_ff        <= bad_in;
   end

   obrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data_byte),
      .rd_en   (ram_re),
      .rd_addr (rp_ff),
      .rd_data (ram_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = byte_valid_ff ? ram_q : '0;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_last         = last_ff;
   assign rsp_bytes_read   = nread_ff;
   assign rsp_fill_count   = fill_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;
   assign rsp_overwrote    = ovw_ff;
   assign rsp_bad_position = bad_ff;

   // read pointer plus count, wrapped, lands on the write pointer between items
   logic [CNT_W:0] inv_sum;
   logic [CNT_W:0] inv_pos;
   assign inv_sum = (CNT_W + 1)'(rp_ff) + {1'b0, cnt_ff};
   assign inv_pos = (inv_sum >= {1'b0, cap_ff}) ? (inv_sum - {1'b0, cap_ff}) : inv_sum;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cap_ff)
      else $error("fill count above capacity");

   a_ptrs_in_range: assert property (@(posedge clock) disable iff (reset)
      (wp_w < cap_ff) && (CNT_W'(rp_ff) < cap_ff))
      else $error("pointer not below capacity");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (rem_ff == '0) |-> (inv_pos == (CNT_W + 1)'(wp_ff)))
      else $error("read pointer, count and write pointer disagree");

   a_issue_has_bytes: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (rem_ff != '0))
      else $error("byte issued with none left");

endmodule

@@ src/overwriting_byte_ring_buffer_core.sv @@
// Top level of the overwriting byte ring buffer: controller plus datapath.
// Depends on obrb_pkg, obrb_if, obrb_ctrl and obrb_datapath.
//
//   port     dir   handshake        carries
//   req_ch   in    valid/ready      action, data_byte, max_len, position
//   rsp_ch   out   valid/ready      byte_out, status and flags per result
//   csr_*    in    csr_we (write)   capacity, 9 bits
//
// Put, head update and byte write are done when taken; the result is registered
// into the output register. A get of n bytes gives n results at one a cycle while
// the result channel does not stall.
// The next item is taken once the last result of the previous one is leaving.
// Reset sets capacity to 256 and empties the buffer; the store is not cleared.
// A stalled result stream holds its byte and the read pointer.
module overwriting_byte_ring_buffer_core import obrb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   obrb_req_if.sink         req_ch,
   obrb_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   obrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   obrb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_ch.action),
      .req_data_byte    (req_ch.data_byte),
      .req_max_len      (req_ch.max_len),
      .req_position     (req_ch.position),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_byte_out     (rsp_ch.byte_out),
      .rsp_byte_valid   (rsp_ch.byte_valid),
      .rsp_last         (rsp_ch.last),
      .rsp_bytes_read   (rsp_ch.bytes_read),
      .rsp_fill_count   (rsp_ch.fill_count),
      .rsp_is_empty     (rsp_ch.is_empty),
      .rsp_is_full      (rsp_ch.is_full),
      .rsp_overwrote    (rsp_ch.overwrote),
      .rsp_bad_position (rsp_ch.bad_position),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

endmodule
